// File: sv/sng_pkg.sv
// ----------------------------------------------------------------------------
// sng_pkg
// shared types, register codes and constants for the stereo noise gate
// ----------------------------------------------------------------------------
package sng_pkg;

	localparam int SAMPLE_BITS   = 24;
	localparam int LEVEL_BITS    = 23;
	localparam int GAIN_BITS     = 24;
	localparam int HOLD_BITS     = 20;
	localparam int EXPO_BITS     = 16;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 24;
	localparam int LOG_BITS      = 21;
	localparam int LOG_STEPS     = 16;
	localparam int LOG_CNT_BITS  = $clog2(LOG_STEPS);

	localparam logic [GAIN_BITS-1:0] ONE_Q23  = 24'h800000;
	localparam logic [47:0]          HALF_Q23 = 48'h000000400000;

	// register reset values
	localparam logic [22:0] OPEN_THR_RST  = 23'd83886;
	localparam logic [22:0] CLOSE_THR_RST = 23'd41806;
	localparam logic [23:0] FLOOR_RST     = 24'd839;
	localparam logic [22:0] GATK_RST      = 23'd8214000;
	localparam logic [22:0] REL_RST       = 23'd8386860;
	localparam logic [22:0] DATK_RST      = 23'd6535000;
	localparam logic [19:0] HOLD_RST      = 20'd2400;
	localparam logic [15:0] EXPO_RST      = 16'd0;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_OPEN_THR  = 3'd0,
		REG_CLOSE_THR = 3'd1,
		REG_FLOOR     = 3'd2,
		REG_GAIN_ATK  = 3'd3,
		REG_RELEASE   = 3'd4,
		REG_DET_ATK   = 3'd5,
		REG_HOLD      = 3'd6,
		REG_EXPO      = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_CLOSED  = 3'd0,
		PH_OPENING = 3'd1,
		PH_OPEN    = 3'd2,
		PH_HOLDING = 3'd3,
		PH_CLOSING = 3'd4
	} gate_phase_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_ENV_A,
		OP_ENV_B,
		OP_PHASE,
		OP_RAMP_A,
		OP_RAMP_B,
		OP_EXP_CHK,
		OP_LOG_LOAD_T,
		OP_LOG_LOAD_L,
		OP_LOG_STEP,
		OP_LOG_SAVE_T,
		OP_LOG_SAVE_L,
		OP_ATTEN,
		OP_INTERP,
		OP_EXP_FLOOR,
		OP_GAIN,
		OP_SCALE_L,
		OP_SCALE_R,
		OP_OUT_LOAD
	} sng_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_ENV_A,
		ST_ENV_B,
		ST_PHASE,
		ST_RAMP_A,
		ST_RAMP_B,
		ST_EXP_CHK,
		ST_LOGT_LOAD,
		ST_LOGT_STEP,
		ST_LOGT_SAVE,
		ST_LOGL_LOAD,
		ST_LOGL_STEP,
		ST_LOGL_SAVE,
		ST_ATTEN,
		ST_INTERP,
		ST_EXP_FLOOR,
		ST_GAIN,
		ST_SCALE_L,
		ST_SCALE_R,
		ST_DONE
	} sng_state_t;

	typedef struct packed {
		sng_op_t op;
	} sng_cmd_t;

	typedef struct packed {
		logic ramp_req;
		logic exp_on;
		logic env_zero;
		logic out_free;
	} sng_status_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_sample;
		logic signed [SAMPLE_BITS-1:0] right_sample;
	} sng_in_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_out;
		logic signed [SAMPLE_BITS-1:0] right_out;
		logic [2:0]                    gate_phase;
		logic [GAIN_BITS-1:0]          out_gain;
	} sng_out_t;

	// 2^(i/16) in q1.15
	function automatic logic [16:0] pow2_tab(input logic [4:0] idx);
		logic [16:0] v;
		case (idx)
			5'd0:  v = 17'd32768;
			5'd1:  v = 17'd34219;
			5'd2:  v = 17'd35734;
			5'd3:  v = 17'd37316;
			5'd4:  v = 17'd38968;
			5'd5:  v = 17'd40693;
			5'd6:  v = 17'd42495;
			5'd7:  v = 17'd44376;
			5'd8:  v = 17'd46341;
			5'd9:  v = 17'd48393;
			5'd10: v = 17'd50535;
			5'd11: v = 17'd52773;
			5'd12: v = 17'd55109;
			5'd13: v = 17'd57549;
			5'd14: v = 17'd60097;
			5'd15: v = 17'd62757;
			default: v = 17'd65536;
		endcase
		return v;
	endfunction

endpackage

// File: sv/sng_stream_if.sv
// ----------------------------------------------------------------------------
// sng_stream_if
// valid/ready stream channel carrying one payload per transfer
// ----------------------------------------------------------------------------
interface sng_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// File: sv/sng_datapath.sv
// ----------------------------------------------------------------------------
// sng_datapath
// config registers, gate state, shared multiplier and output register
// ----------------------------------------------------------------------------
module sng_datapath import sng_pkg::*; #(
	parameter int SNAP_EPSILON = 8389
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	input  sng_in_t                  in_payload,
	input  sng_cmd_t                 cmd,
	output sng_status_t              status,
	output logic                     out_valid,
	input  logic                     out_ready,
	output sng_out_t                 out_payload
);

	localparam logic [24:0] EPS = 25'(SNAP_EPSILON);

	// config
	logic [22:0] open_thr_q, close_thr_q, gatk_q, rel_q, datk_q;
	logic [23:0] floor_q;
	logic [19:0] hold_cnt_q;
	logic [15:0] expo_q;

	// gate state
	logic [LEVEL_BITS-1:0] env_q;
	logic [GAIN_BITS-1:0]  ramp_q;
	gate_phase_t           phase_q;
	logic [HOLD_BITS-1:0]  hold_q;
	logic                  out_valid_q;
	sng_out_t              out_q;

	// working registers
	logic signed [SAMPLE_BITS-1:0] left_q, right_q;
	logic [46:0]            acc_q;
	logic [30:0]            m_q;
	logic [4:0]             p_q;
	logic [15:0]            frac_q;
	logic [LOG_BITS-1:0]    lthr_q, llev_q;
	logic [24:0]            a_q;
	logic [16:0]            val_q;
	logic [GAIN_BITS-1:0]   ex_q, applied_q;
	logic [SAMPLE_BITS-1:0] res_l_q, res_r_q;

	logic [23:0] fl, mag_l, mag_r, peak_w;
	logic [22:0] peak, env_c, ramp_c;
	logic [23:0] ramp_tgt;
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	logic [47:0] rsum;
	logic [22:0] log_x;
	logic [4:0]  p_new;
	logic [30:0] m_load;
	logic [31:0] sq;
	logic [LOG_BITS-1:0] d;
	logic [16:0] g, diff;
	logic [4:0]  idx;
	logic [5:0]  sh;
	logic [24:0] e_sh;
	logic [23:0] e;
	logic [24:0] mag_rnd;
	logic [23:0] scaled;
	logic        cur_neg;
	logic [23:0] ramp_new;
	logic [22:0] env_new;

	assign fl = (floor_q > ONE_Q23) ? ONE_Q23 : floor_q;

	assign mag_l  = left_q[SAMPLE_BITS-1] ? 24'(~left_q + 1'b1) : 24'(left_q);
	assign mag_r  = right_q[SAMPLE_BITS-1] ? 24'(~right_q + 1'b1) : 24'(right_q);
	assign peak_w = (mag_l > mag_r) ? mag_l : mag_r;
	assign peak   = peak_w[23] ? 23'h7FFFFF : peak_w[22:0];

	assign env_c    = ({1'b0, peak} > {1'b0, env_q}) ? datk_q : rel_q;
	assign ramp_c   = (phase_q == PH_OPENING) ? gatk_q : rel_q;
	assign ramp_tgt = (phase_q == PH_OPENING) ? ONE_Q23 : fl;

	// log2 front end: leading one and normalized mantissa
	assign log_x = (cmd.op == OP_LOG_LOAD_L) ? env_q : open_thr_q;
	always_comb begin
		p_new = '0;
		for (int i = 0; i < LEVEL_BITS; i++) begin
			if (log_x[i]) p_new = 5'(i);
		end
	end
	assign m_load = 31'({8'b0, log_x} << (5'd30 - p_new));

	assign d    = lthr_q - llev_q;
	assign g    = 17'h10000 - {1'b0, a_q[15:0]};
	assign idx  = g[16:12];
	assign diff = pow2_tab(idx + 5'd1) - pow2_tab(idx);
	assign sh   = {1'b0, a_q[20:16]} + 6'd1;
	assign e_sh = {val_q, 8'b0} >> sh;
	assign e    = (a_q[24:16] >= 9'd31) ? 24'd0 : e_sh[23:0];

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_ENV_A: begin
				mul_a = 32'(env_c);
				mul_b = 32'(env_q);
			end
			OP_ENV_B: begin
				mul_a = 32'(ONE_Q23 - {1'b0, env_c});
				mul_b = 32'(peak);
			end
			OP_RAMP_A: begin
				mul_a = 32'(ramp_c);
				mul_b = 32'(ramp_q);
			end
			OP_RAMP_B: begin
				mul_a = 32'(ONE_Q23 - {1'b0, ramp_c});
				mul_b = 32'(ramp_tgt);
			end
			OP_LOG_STEP: begin
				mul_a = 32'(m_q);
				mul_b = 32'(m_q);
			end
			OP_ATTEN: begin
				mul_a = 32'(d);
				mul_b = 32'(expo_q);
			end
			OP_INTERP: begin
				mul_a = 32'(diff);
				mul_b = 32'(g[11:0]);
			end
			OP_GAIN: begin
				mul_a = 32'(ramp_q);
				mul_b = 32'(ex_q);
			end
			OP_SCALE_L: begin
				mul_a = 32'(mag_l);
				mul_b = 32'(applied_q);
			end
			OP_SCALE_R: begin
				mul_a = 32'(mag_r);
				mul_b = 32'(applied_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = {32'b0, mul_a} * {32'b0, mul_b};

	// second half of a one-pole update, also rounding of gain and scale
	always_comb begin
		if (cmd.op == OP_ENV_B || cmd.op == OP_RAMP_B)
			rsum = {1'b0, acc_q} + prod[47:0] + HALF_Q23;
		else
			rsum = prod[47:0] + HALF_Q23;
	end
	assign env_new  = rsum[45:23];
	assign ramp_new = rsum[46:23];

	assign sq = prod[61:30];

	// sample scaling with sign and saturation
	assign cur_neg = (cmd.op == OP_SCALE_L) ? left_q[SAMPLE_BITS-1] : right_q[SAMPLE_BITS-1];
	assign mag_rnd = rsum[47:23];
	always_comb begin
		if (cur_neg) begin
			if (mag_rnd > {1'b0, ONE_Q23})
				scaled = ONE_Q23;
			else
				scaled = 24'(~mag_rnd + 1'b1);
		end else begin
			if (mag_rnd > 25'h7FFFFF)
				scaled = 24'h7FFFFF;
			else
				scaled = mag_rnd[23:0];
		end
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_thr_q  <= OPEN_THR_RST;
			close_thr_q <= CLOSE_THR_RST;
			floor_q     <= FLOOR_RST;
			gatk_q      <= GATK_RST;
			rel_q       <= REL_RST;
			datk_q      <= DATK_RST;
			hold_cnt_q  <= HOLD_RST;
			expo_q      <= EXPO_RST;
			env_q       <= '0;
			ramp_q      <= FLOOR_RST;
			phase_q     <= PH_CLOSED;
			hold_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_OPEN_THR:  open_thr_q  <= cfg_data[22:0];
					REG_CLOSE_THR: close_thr_q <= cfg_data[22:0];
					REG_FLOOR:     floor_q     <= cfg_data[23:0];
					REG_GAIN_ATK:  gatk_q      <= cfg_data[22:0];
					REG_RELEASE:   rel_q       <= cfg_data[22:0];
					REG_DET_ATK:   datk_q      <= cfg_data[22:0];
					REG_HOLD:      hold_cnt_q  <= cfg_data[19:0];
					REG_EXPO:      expo_q      <= cfg_data[15:0];
				endcase
			end

			if (cmd.op == OP_ENV_B) env_q <= env_new;

			if (cmd.op == OP_PHASE) begin
				unique case (phase_q)
					PH_OPENING: begin
						phase_q <= PH_OPENING;
					end
					PH_OPEN: begin
						if (env_q < close_thr_q) begin
							hold_q  <= hold_cnt_q;
							phase_q <= PH_HOLDING;
						end
					end
					PH_HOLDING: begin
						if (env_q > close_thr_q)
							phase_q <= PH_OPEN;
						else if (hold_q == '0)
							phase_q <= PH_CLOSING;
						else
							hold_q <= hold_q - 1'b1;
					end
					PH_CLOSING: begin
						if (env_q > open_thr_q) phase_q <= PH_OPENING;
					end
					default: begin
						phase_q <= (env_q > open_thr_q) ? PH_OPENING : PH_CLOSED;
					end
				endcase
			end

			if (cmd.op == OP_RAMP_B) begin
				if (phase_q == PH_OPENING) begin
					if ({1'b0, ramp_new} + EPS >= {1'b0, ONE_Q23}) begin
						ramp_q  <= ONE_Q23;
						phase_q <= PH_OPEN;
					end else begin
						ramp_q <= ramp_new;
					end
				end else begin
					if ({1'b0, ramp_new} <= {1'b0, fl} + EPS) begin
						ramp_q  <= fl;
						phase_q <= PH_CLOSED;
					end else begin
						ramp_q <= ramp_new;
					end
				end
			end

			if (cmd.op == OP_OUT_LOAD)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// working registers, no reset
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_CAPTURE: begin
				left_q  <= in_payload.left_sample;
				right_q <= in_payload.right_sample;
			end
			OP_ENV_A, OP_RAMP_A: acc_q <= prod[46:0];
			OP_EXP_CHK: begin
				if (status.exp_on)
					ex_q <= fl;
				else
					applied_q <= (phase_q == PH_CLOSED) ? fl : ramp_q;
			end
			OP_LOG_LOAD_T, OP_LOG_LOAD_L: begin
				m_q    <= m_load;
				p_q    <= p_new;
				frac_q <= '0;
			end
			OP_LOG_STEP: begin
				if (sq[31]) begin
					m_q    <= sq[31:1];
					frac_q <= {frac_q[14:0], 1'b1};
				end else begin
					m_q    <= sq[30:0];
					frac_q <= {frac_q[14:0], 1'b0};
				end
			end
			OP_LOG_SAVE_T: lthr_q <= {p_q, frac_q};
			OP_LOG_SAVE_L: llev_q <= {p_q, frac_q};
			OP_ATTEN:      a_q    <= prod[36:12];
			OP_INTERP: begin
				if (idx >= 5'd16)
					val_q <= 17'd65536;
				else
					val_q <= pow2_tab(idx) + {5'b0, prod[23:12]};
			end
			OP_EXP_FLOOR: ex_q      <= (e < fl) ? fl : e;
			OP_GAIN:      applied_q <= rsum[46:23];
			OP_SCALE_L:   res_l_q   <= scaled;
			OP_SCALE_R:   res_r_q   <= scaled;
			OP_OUT_LOAD: begin
				out_q.left_out   <= res_l_q;
				out_q.right_out  <= res_r_q;
				out_q.gate_phase <= phase_q;
				out_q.out_gain   <= applied_q;
			end
			default: begin
			end
		endcase
	end

	assign status.ramp_req = (phase_q == PH_OPENING) ||
		(phase_q == PH_CLOSING && !(env_q > open_thr_q));
	assign status.exp_on   = (phase_q == PH_OPEN || phase_q == PH_OPENING) &&
		(expo_q != '0) && (env_q < open_thr_q) && (open_thr_q != '0);
	assign status.env_zero = (env_q == '0);
	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign out_payload = out_q;

	a_gain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.out_gain <= ONE_Q23)
		else $error("applied gain above unity");

	a_hold_only_in_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op != OP_PHASE) |=> $stable(hold_q))
		else $error("hold counter moved outside phase update");

endmodule

// File: sv/sng_controller.sv
// ----------------------------------------------------------------------------
// sng_controller
// sequencer stepping the datapath through one stereo pair
// ----------------------------------------------------------------------------
module sng_controller import sng_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  sng_status_t status,
	output sng_cmd_t    cmd
);

	sng_state_t state_q, state_d;
	logic [LOG_CNT_BITS-1:0] cnt_q;
	logic last_step;

	assign last_step = (cnt_q == LOG_CNT_BITS'(LOG_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (state_q == ST_LOGT_STEP || state_q == ST_LOGL_STEP)
			cnt_q <= cnt_q + 1'b1;
		else
			cnt_q <= '0;
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_CAPTURE;
					state_d = ST_ENV_A;
				end
			end
			ST_ENV_A: begin
				cmd.op  = OP_ENV_A;
				state_d = ST_ENV_B;
			end
			ST_ENV_B: begin
				cmd.op  = OP_ENV_B;
				state_d = ST_PHASE;
			end
			ST_PHASE: begin
				cmd.op  = OP_PHASE;
				state_d = status.ramp_req ? ST_RAMP_A : ST_EXP_CHK;
			end
			ST_RAMP_A: begin
				cmd.op  = OP_RAMP_A;
				state_d = ST_RAMP_B;
			end
			ST_RAMP_B: begin
				cmd.op  = OP_RAMP_B;
				state_d = ST_EXP_CHK;
			end
			ST_EXP_CHK: begin
				cmd.op = OP_EXP_CHK;
				if (!status.exp_on)
					state_d = ST_SCALE_L;
				else if (status.env_zero)
					state_d = ST_GAIN;
				else
					state_d = ST_LOGT_LOAD;
			end
			ST_LOGT_LOAD: begin
				cmd.op  = OP_LOG_LOAD_T;
				state_d = ST_LOGT_STEP;
			end
			ST_LOGT_STEP: begin
				cmd.op = OP_LOG_STEP;
				if (last_step) state_d = ST_LOGT_SAVE;
			end
			ST_LOGT_SAVE: begin
				cmd.op  = OP_LOG_SAVE_T;
				state_d = ST_LOGL_LOAD;
			end
			ST_LOGL_LOAD: begin
				cmd.op  = OP_LOG_LOAD_L;
				state_d = ST_LOGL_STEP;
			end
			ST_LOGL_STEP: begin
				cmd.op = OP_LOG_STEP;
				if (last_step) state_d = ST_LOGL_SAVE;
			end
			ST_LOGL_SAVE: begin
				cmd.op  = OP_LOG_SAVE_L;
				state_d = ST_ATTEN;
			end
			ST_ATTEN: begin
				cmd.op  = OP_ATTEN;
				state_d = ST_INTERP;
			end
			ST_INTERP: begin
				cmd.op  = OP_INTERP;
				state_d = ST_EXP_FLOOR;
			end
			ST_EXP_FLOOR: begin
				cmd.op  = OP_EXP_FLOOR;
				state_d = ST_GAIN;
			end
			ST_GAIN: begin
				cmd.op  = OP_GAIN;
				state_d = ST_SCALE_L;
			end
			ST_SCALE_L: begin
				cmd.op  = OP_SCALE_L;
				state_d = ST_SCALE_R;
			end
			ST_SCALE_R: begin
				cmd.op  = OP_SCALE_R;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.op  = OP_OUT_LOAD;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid) |=> state_q == ST_ENV_A)
		else $error("accepted pair did not start detector update");

	a_done_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !status.out_free) |=> state_q == ST_DONE)
		else $error("result dropped while output register busy");

endmodule

// File: sv/stereo_noise_gate_expander.sv
// ----------------------------------------------------------------------------
// stereo_noise_gate_expander
// stereo noise gate with hysteresis, hold and downward expander
// ----------------------------------------------------------------------------
// usage:
//  - samples channel: one stereo pair per transfer (valid/ready)
//  - results channel: scaled pair, gate phase and applied gain per transfer
//  - cfg_we/cfg_index/cfg_data: register writes, only while the block is idle
//  - one pair is processed at a time by a sequencer around one shared
//    32x32 multiplier; a pair runs the detector update, the phase step,
//    the gain ramp while it moves, the expander check and the scaling of
//    both channels; expansion at a zero level adds a gain step, the full
//    expander two 16-step log2 iterations, exponent, floor and gain steps
//  - the result is registered on the results channel after the last step;
//    the output register frees the input side, so the next pair is taken
//    while a result still waits
//  - a stalled receiver holds the result; the sequencer parks at its last
//    step until the output register is free, then accepts again
//  - reset clears the detector, closes the gate at the floor gain and
//    loads the register defaults
// ----------------------------------------------------------------------------
module stereo_noise_gate_expander import sng_pkg::*; #(
	parameter int SNAP_EPSILON = 8389
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	sng_stream_if.sink               samples,
	sng_stream_if.source             results
);

	sng_cmd_t    cmd;
	sng_status_t status;
	sng_in_t     in_payload;
	sng_out_t    out_payload;

	assign in_payload.left_sample  = samples.payload.left_sample;
	assign in_payload.right_sample = samples.payload.right_sample;

	// sequencer: input handshake and step commands
	sng_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath: registers, gate state, multiplier, output register
	sng_datapath #(
		.SNAP_EPSILON (SNAP_EPSILON)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_payload  (in_payload),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (results.valid),
		.out_ready   (results.ready),
		.out_payload (out_payload)
	);

	assign results.payload = out_payload;

endmodule
